@@ rtl/rgb_to_hsl_fixed_core_defines.svh @@
// Assertion macros shared by the RGB to HSL converter RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef RGB_TO_HSL_FIXED_CORE_DEFINES_SVH
`define RGB_TO_HSL_FIXED_CORE_DEFINES_SVH

// Checks a condition at every clock edge.
`define RTH_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define RTH_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ rtl/rth_pkg.sv @@
// Package for the RGB to HSL converter: widths, scaling constants, hue sector
// codes and the side-information struct. No dependencies.
`default_nettype none

package rth_pkg;

    localparam int CHAN_W       = 8;
    localparam int SUM_W        = 9;
    localparam int NUM_W        = 22;
    localparam int QUOT_W       = 14;
    localparam int HUE_W        = 16;
    localparam int PCT_W        = 14;
    localparam int PROD_W       = 38;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 48;

    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = QUOT_W;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [NUM_W-1:0]  SCALE_PCT   = NUM_W'(10000);
    localparam logic [NUM_W-1:0]  HUE_SECTOR  = NUM_W'(6000);
    localparam logic [SUM_W-1:0]  SUM_FULL    = SUM_W'(510);
    localparam logic [SUM_W-1:0]  CHAN_MAX    = SUM_W'(255);
    localparam logic [HUE_W-1:0]  HUE_GREEN   = HUE_W'(12000);
    localparam logic [HUE_W-1:0]  HUE_BLUE    = HUE_W'(24000);
    localparam logic [HUE_W-1:0]  HUE_TURN    = HUE_W'(36000);
    localparam logic [PCT_W-1:0]  PCT_FULL    = PCT_W'(10000);

    // floor(2^23 / 255); the estimate it gives is low by at most one.
    localparam logic [15:0]       LIGHT_RECIP = 16'd32896;
    localparam int                LIGHT_SHIFT = 23;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [PCT_W-1:0] light;
        logic [1:0]       sector;
        logic             neg;
        logic             grey;
    } rth_side_t;

endpackage

`default_nettype wire

@@ rtl/rth_front.sv @@
// Front stages of the converter: max/min and sector select, dividend scaling,
// and lightness by reciprocal multiply. Depends on rth_pkg.
`default_nettype none

module rth_front
    import rth_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic [FRONT_STAGES-1:0]  adv,
    input  wire logic [CHAN_W-1:0]        red,
    input  wire logic [CHAN_W-1:0]        green,
    input  wire logic [CHAN_W-1:0]        blue,
    output logic      [NUM_W-1:0]         sat_num,
    output logic      [CHAN_W-1:0]        sat_den,
    output logic      [NUM_W-1:0]         hue_num,
    output logic      [CHAN_W-1:0]        hue_den,
    output rth_side_t                     side
);

    // Stage A: classification.
    logic [CHAN_W-1:0] mx, mn, pos_a, pos_b, mag;
    logic [1:0]        sector;
    logic              neg;
    logic [SUM_W-1:0]  sum;

    logic [SUM_W-1:0]  a_sum_reg;
    logic [CHAN_W-1:0] a_chroma_reg, a_span_reg, a_mag_reg;
    logic [1:0]        a_sector_reg;
    logic              a_neg_reg;

    always_comb begin
        if (red >= green && red >= blue) begin
            sector = SECT_RED;
            mx     = red;
            pos_a  = green;
            pos_b  = blue;
        end else if (green >= blue) begin
            sector = SECT_GREEN;
            mx     = green;
            pos_a  = blue;
            pos_b  = red;
        end else begin
            sector = SECT_BLUE;
            mx     = blue;
            pos_a  = red;
            pos_b  = green;
        end
        mn = red;
        if (green < mn) begin
            mn = green;
        end
        if (blue < mn) begin
            mn = blue;
        end
        if (pos_a >= pos_b) begin
            mag = pos_a - pos_b;
            neg = 1'b0;
        end else begin
            mag = pos_b - pos_a;
            neg = 1'b1;
        end
        sum = SUM_W'(mx) + SUM_W'(mn);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a_sum_reg    <= sum;
            a_chroma_reg <= mx - mn;
            a_span_reg   <= (sum < CHAN_MAX) ? sum[CHAN_W-1:0]
                                             : CHAN_W'(SUM_FULL - sum);
            a_mag_reg    <= mag;
            a_sector_reg <= sector;
            a_neg_reg    <= neg;
        end
    end

    // Stage B: scaled dividends and half of the lightness numerator.
    logic [NUM_W:0]    light_x;
    logic [NUM_W-1:0]  b_sat_num_reg, b_hue_num_reg, b_y_reg;
    logic [CHAN_W-1:0] b_chroma_reg, b_span_reg;
    logic [1:0]        b_sector_reg;
    logic              b_neg_reg;

    assign light_x = (NUM_W+1)'(a_sum_reg) * (NUM_W+1)'(SCALE_PCT) + (NUM_W+1)'(CHAN_MAX);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            b_sat_num_reg <= NUM_W'(a_chroma_reg) * SCALE_PCT
                             + NUM_W'(a_span_reg[CHAN_W-1:1]);
            b_hue_num_reg <= NUM_W'(a_mag_reg) * HUE_SECTOR;
            b_y_reg       <= light_x[NUM_W:1];
            b_chroma_reg  <= a_chroma_reg;
            b_span_reg    <= a_span_reg;
            b_sector_reg  <= a_sector_reg;
            b_neg_reg     <= a_neg_reg;
        end
    end

    // Stage C: reciprocal multiply for y / 255.
    logic [PROD_W-1:0] c_prod_reg;
    logic [NUM_W-1:0]  c_sat_num_reg, c_hue_num_reg, c_y_reg;
    logic [CHAN_W-1:0] c_chroma_reg, c_span_reg;
    logic [1:0]        c_sector_reg;
    logic              c_neg_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            c_prod_reg    <= PROD_W'(b_y_reg) * PROD_W'(LIGHT_RECIP);
            c_sat_num_reg <= b_sat_num_reg;
            c_hue_num_reg <= b_hue_num_reg;
            c_y_reg       <= b_y_reg;
            c_chroma_reg  <= b_chroma_reg;
            c_span_reg    <= b_span_reg;
            c_sector_reg  <= b_sector_reg;
            c_neg_reg     <= b_neg_reg;
        end
    end

    // Stage D: the estimate is exact or one low; one compare fixes it.
    logic [PCT_W-1:0] q_est, light;
    logic [NUM_W-1:0] q_times, rem;

    assign q_est   = c_prod_reg[LIGHT_SHIFT +: PCT_W];
    assign q_times = (NUM_W'(q_est) << CHAN_W) - NUM_W'(q_est);
    assign rem     = c_y_reg - q_times;
    assign light   = (rem >= NUM_W'(CHAN_MAX)) ? q_est + PCT_W'(1) : q_est;

    logic [NUM_W-1:0]  d_sat_num_reg, d_hue_num_reg;
    logic [CHAN_W-1:0] d_sat_den_reg, d_hue_den_reg;
    rth_side_t         d_side_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            d_sat_num_reg     <= c_sat_num_reg;
            d_hue_num_reg     <= c_hue_num_reg;
            d_sat_den_reg     <= c_span_reg;
            d_hue_den_reg     <= c_chroma_reg;
            d_side_reg.light  <= light;
            d_side_reg.sector <= c_sector_reg;
            d_side_reg.neg    <= c_neg_reg;
            d_side_reg.grey   <= (c_chroma_reg == '0);
        end
    end

    assign sat_num = d_sat_num_reg;
    assign sat_den = d_sat_den_reg;
    assign hue_num = d_hue_num_reg;
    assign hue_den = d_hue_den_reg;
    assign side    = d_side_reg;

endmodule

`default_nettype wire

@@ rtl/rth_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUOT_W bits. Depends on rth_pkg.
`default_nettype none

module rth_divider
    import rth_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic [DIV_STAGES-1:0]  adv,
    input  wire logic [NUM_W-1:0]       num,
    input  wire logic [CHAN_W-1:0]      den,
    output logic      [QUOT_W-1:0]      quot
);

    logic [NUM_W-1:0]  rem_reg   [DIV_STAGES];
    logic [CHAN_W-1:0] den_reg   [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg  [DIV_STAGES];

    logic [NUM_W-1:0]  rem_in    [DIV_STAGES];
    logic [CHAN_W-1:0] den_in    [DIV_STAGES];
    logic [QUOT_W-1:0] quot_in   [DIV_STAGES];
    logic [NUM_W-1:0]  trial     [DIV_STAGES];
    logic [NUM_W-1:0]  rem_next  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_next [DIV_STAGES];

    // Stage k decides quotient bit QUOT_W-1-k.
    always_comb begin
        rem_in[0]  = num;
        den_in[0]  = den;
        quot_in[0] = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            rem_in[k]  = rem_reg[k-1];
            den_in[k]  = den_reg[k-1];
            quot_in[k] = quot_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            trial[k]     = NUM_W'(den_in[k]) << (QUOT_W - 1 - k);
            quot_next[k] = quot_in[k];
            if (rem_in[k] >= trial[k]) begin
                rem_next[k]                   = rem_in[k] - trial[k];
                quot_next[k][QUOT_W - 1 - k]  = 1'b1;
            end else begin
                rem_next[k] = rem_in[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_in[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/rth_back.sv @@
// Output stage: folds the hue quotient into its sector, clears hue and saturation
// of grey pixels and registers the result fields. Depends on rth_pkg.
`default_nettype none

module rth_back
    import rth_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic [QUOT_W-1:0]  sat_quot,
    input  wire logic [QUOT_W-1:0]  hue_quot,
    input  wire rth_side_t          side,
    output logic      [HUE_W-1:0]   hue,
    output logic      [PCT_W-1:0]   saturation,
    output logic      [PCT_W-1:0]   lightness
);

    logic [HUE_W-1:0] hq, hue_next;
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg, light_reg;

    assign hq = HUE_W'(hue_quot);

    always_comb begin
        case (side.sector)
            SECT_RED: begin
                if (side.neg && hq != '0) begin
                    hue_next = HUE_TURN - hq;
                end else begin
                    hue_next = side.neg ? '0 : hq;
                end
            end
            SECT_GREEN: hue_next = side.neg ? HUE_GREEN - hq : HUE_GREEN + hq;
            SECT_BLUE:  hue_next = side.neg ? HUE_BLUE - hq : HUE_BLUE + hq;
            default:    hue_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hue_reg   <= side.grey ? '0 : hue_next;
            sat_reg   <= side.grey ? '0 : sat_quot;
            light_reg <= side.light;
        end
    end

    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsl_fixed_core.sv @@
// Top level of the RGB to HSL converter: stream ports, per-stage valid and
// advance control, side-data pipe. Depends on rth_pkg, rth_front, rth_divider,
// rth_back and rgb_to_hsl_fixed_core_defines.svh.
//
//   Channel  Dir  Handshake           Payload
//   s_       in   s_tvalid/s_tready   red [7:0], green [15:8], blue [23:16]
//   m_       out  m_tvalid/m_tready   hue [15:0], saturation [29:16],
//                                     lightness [43:30], zero [47:44]
//
// The converter takes one item per cycle unless the pipeline is full and stalled.
// The pipeline has four front stages, fourteen divider stages (one
// quotient bit each, for both dividers side by side) and the output register.
// Reset clears only the valid bits; a stage holds its item while the stage after it
// is full and stalled, and an empty stage anywhere downstream lets the stages
// in front of it move up, so input is still taken while a result waits.
`default_nettype none
`include "rgb_to_hsl_fixed_core_defines.svh"

module rgb_to_hsl_fixed_core
    import rth_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata    // hue, saturation, lightness, pad
);

    // One valid bit per register stage. A stage moves unless it and every
    // stage after it are full, and always when the output is being taken.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_STAGES; gi++) begin : g_adv
            assign adv[gi] = m_tready || !(&valid_reg[NUM_STAGES-1:gi]);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // Front: classification, scaling and lightness.
    logic [NUM_W-1:0]  sat_num, hue_num;
    logic [CHAN_W-1:0] sat_den, hue_den;
    rth_side_t         front_side;

    rth_front u_front (
        .aclk    (aclk),
        .adv     (adv[FRONT_STAGES-1:0]),
        .red     (s_tdata[CHAN_W-1:0]),
        .green   (s_tdata[2*CHAN_W-1:CHAN_W]),
        .blue    (s_tdata[3*CHAN_W-1:2*CHAN_W]),
        .sat_num (sat_num),
        .sat_den (sat_den),
        .hue_num (hue_num),
        .hue_den (hue_den),
        .side    (front_side)
    );

    // Saturation and hue magnitude are divided side by side.
    logic [QUOT_W-1:0] sat_quot, hue_quot;

    rth_divider u_sat_div (
        .aclk (aclk),
        .adv  (adv[FRONT_STAGES +: DIV_STAGES]),
        .num  (sat_num),
        .den  (sat_den),
        .quot (sat_quot)
    );

    rth_divider u_hue_div (
        .aclk (aclk),
        .adv  (adv[FRONT_STAGES +: DIV_STAGES]),
        .num  (hue_num),
        .den  (hue_den),
        .quot (hue_quot)
    );

    // The lightness, sector and sign ride along with the divider stages.
    rth_side_t side_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (adv[FRONT_STAGES]) begin
            side_reg[0] <= front_side;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (adv[FRONT_STAGES + k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation, lightness;

    rth_back u_back (
        .aclk       (aclk),
        .load       (adv[NUM_STAGES-1]),
        .sat_quot   (sat_quot),
        .hue_quot   (hue_quot),
        .side       (side_reg[DIV_STAGES-1]),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    assign m_tdata = {(M_TDATA_W - HUE_W - 2*PCT_W)'(0), lightness, saturation, hue};

    // A colored pixel always has nonzero saturation, so zero saturation
    // means a grey pixel, whose hue must be zero.
    `RTH_ASSERT_NOW(a_hue_range, !m_tvalid || hue < HUE_TURN, "hue out of range")
    `RTH_ASSERT_NOW(a_sat_range, !m_tvalid || saturation <= PCT_FULL, "saturation out of range")
    `RTH_ASSERT_NOW(a_light_range, !m_tvalid || lightness <= PCT_FULL, "lightness out of range")
    `RTH_ASSERT_NOW(a_grey_hue, !m_tvalid || saturation != '0 || hue == '0, "grey result has a hue")
    `RTH_ASSERT_NEXT(a_accept_valid, s_tvalid && s_tready, valid_reg[0], "accepted item lost")

endmodule

`default_nettype wire

@@ test/rgb_to_hsl_fixed_core_tb.sv @@
// Self-checking testbench for rgb_to_hsl_fixed_core: directed corner pixels,
// then about a thousand random pixels, mostly under random back-pressure on both streams.
// Depends on rth_pkg and the converter RTL; it reads no files.
`timescale 1ns / 1ps

module rgb_to_hsl_fixed_core_tb;
    import rth_pkg::*;

    // Integer copies of the scaling constants, so that the expected values are
    // worked out in signed 32-bit arithmetic like the converter's definition.
    localparam int PCT_SCALE  = 10000;
    localparam int FULL_SUM   = 510;
    localparam int MID_SUM    = 255;
    localparam int SECTOR_DEG = 6000;
    localparam int GREEN_DEG  = 12000;
    localparam int BLUE_DEG   = 24000;
    localparam int TURN_DEG   = 36000;

    localparam int RANDOM_PIXELS = 1000;
    localparam int BURST_PIXELS  = 60;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
    } hsl_pixel_t;

    // Holds the HSL values still owed by the converter, oldest first, and
    // compares every result word that leaves the master side against them.
    class hsl_scoreboard;
        hsl_pixel_t owed_q[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // Computes the HSL triple for one pixel.
        function hsl_pixel_t rgb_to_hsl(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                        logic [CHAN_W-1:0] b);
            hsl_pixel_t res;
            int red, grn, blu, hi, lo, sum, chroma, span, hue, sat, light;
            red = r;
            grn = g;
            blu = b;
            hi = red;
            lo = red;
            if (grn > hi) hi = grn;
            if (blu > hi) hi = blu;
            if (grn < lo) lo = grn;
            if (blu < lo) lo = blu;
            sum = hi + lo;
            chroma = hi - lo;
            light = (sum * PCT_SCALE + MID_SUM) / FULL_SUM;
            hue = 0;
            sat = 0;
            if (chroma != 0) begin
                span = (sum < MID_SUM) ? sum : FULL_SUM - sum;
                sat = (chroma * PCT_SCALE + span / 2) / span;
                // Ties for the largest channel go to red first, then green.
                // Division of signed ints truncates toward zero.
                if (hi == red)
                    hue = SECTOR_DEG * (grn - blu) / chroma;
                else if (hi == grn)
                    hue = GREEN_DEG + SECTOR_DEG * (blu - red) / chroma;
                else
                    hue = BLUE_DEG + SECTOR_DEG * (red - grn) / chroma;
                if (hue < 0) hue += TURN_DEG;
            end
            res.hue = hue[HUE_W-1:0];
            res.sat = sat[PCT_W-1:0];
            res.light = light[PCT_W-1:0];
            return res;
        endfunction

        function void note_pixel(logic [S_TDATA_W-1:0] word);
            owed_q.push_back(rgb_to_hsl(word[7:0], word[15:8], word[23:16]));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            hsl_pixel_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, word);
                failures++;
                return;
            end
            want = owed_q.pop_front();
            if (word[15:0] !== want.hue) begin
                $display("%0t: hue mismatch: expected %0d, actual %0d",
                         $time, want.hue, word[15:0]);
                failures++;
            end
            if (word[29:16] !== want.sat) begin
                $display("%0t: saturation mismatch: expected %0d, actual %0d",
                         $time, want.sat, word[29:16]);
                failures++;
            end
            if (word[43:30] !== want.light) begin
                $display("%0t: lightness mismatch: expected %0d, actual %0d",
                         $time, want.light, word[43:30]);
                failures++;
            end
            if (word[47:44] !== 4'd0) begin
                $display("%0t: padding mismatch: expected 0, actual %h", $time, word[47:44]);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // red, green, blue
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // hue, saturation, lightness, zero pad

    hsl_scoreboard sb = new();

    // Both streams insert random gaps while this is set; clearing it gives
    // stretches at the full rate of one item per cycle unless the receiver holds off.
    bit gaps_on;
    // A long receiver hold-off requested by the stimulus; the receiver
    // process counts it down itself.
    int rx_hold_cycles;

    rgb_to_hsl_fixed_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random pixel, weighted toward grey pixels, tied channels and values
    // near the ends of the range, which are where the arithmetic turns.
    function automatic logic [S_TDATA_W-1:0] random_pixel();
        logic [CHAN_W-1:0] ch [3];
        int unsigned kind;
        int i;
        int j;
        kind = $urandom_range(0, 99);
        foreach (ch[k]) ch[k] = CHAN_W'($urandom_range(0, 255));
        if (kind < 10) begin
            ch[1] = ch[0];
            ch[2] = ch[0];
        end else if (kind < 25) begin
            i = $urandom_range(0, 2);
            j = (i + 1 + $urandom_range(0, 1)) % 3;
            ch[j] = ch[i];
        end else if (kind < 35) begin
            foreach (ch[k])
                ch[k] = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 1))
                                             : CHAN_W'(255 - $urandom_range(0, 1));
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // Offers one pixel and returns once the converter has taken it. Called
    // right after the previous acceptance edge, so the first negedge here is
    // where s_tvalid either stays high or drops for a gap.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel({b, g, r});
    endtask

    task automatic send_random(input int count);
        logic [S_TDATA_W-1:0] px;
        repeat (count) begin
            px = random_pixel();
            send_pixel(px[7:0], px[15:8], px[23:16]);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Receiver: drives m_tready at each falling edge. A requested hold-off
    // wins over the random stalls.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Every result word taken on the master side is checked in order.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        gaps_on = 1'b1;
        rx_hold_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Black, white, a mid grey and a near-black grey: hue and saturation must be zero.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        // Pure primaries and secondaries, plus ties for the maximum between each pair of channels.
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd200 - 8'd1);
        send_pixel(8'd10, 8'd90, 8'd90);
        // Red largest with blue above green: the hue goes negative and wraps.
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd20, 8'd180);
        // Smallest chroma at both ends of the lightness range.
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0, 8'd0, 8'd1);
        // Sum of largest and smallest channel at the span switch, and two pixels with a lower sum.
        send_pixel(8'd127, 8'd127, 8'd0);
        send_pixel(8'd200, 8'd55, 8'd100);
        send_pixel(8'd128, 8'd128, 8'd0);
        // Truncation toward zero on odd chroma, in each hue sector.
        send_pixel(8'd7, 8'd100, 8'd3);
        send_pixel(8'd3, 8'd7, 8'd100);
        send_pixel(8'd100, 8'd3, 8'd7);

        // Random pixels with gaps on both sides.
        send_random(400);

        // Receiver holds off while the sender streams back to back, so the
        // pipeline fills and s_tready must drop.
        gaps_on = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        send_random(BURST_PIXELS);

        // Sender stops offering and pauses until the converter has returned
        // everything.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();

        // Full-rate stretch with no gaps on either side.
        send_random(200);

        gaps_on = 1'b1;
        send_random(RANDOM_PIXELS - 400 - BURST_PIXELS - 200);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (NUM_STAGES + 10) @(posedge aclk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d results still expected at the end, actual none",
                     $time, sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
